@@ rtl/utcal_pkg.sv @@
package utcal_pkg;

  // Field widths
  localparam int SECS_W  = 40;
  localparam int OFF_W   = 11;
  localparam int YEAR_W  = 16;
  localparam int MONTH_W = 4;
  localparam int MDAY_W  = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int WDAY_W  = 3;
  localparam int YDAY_W  = 9;

  // Offset clamp limits, minutes
  localparam logic signed [OFF_W-1:0] OFF_LOW  = -11'sd720;
  localparam logic signed [OFF_W-1:0] OFF_HIGH = 11'sd840;
  localparam int LOC_W = 17;            // offset in seconds, signed

  // Biased local seconds: local + (719468 + 39 * 146097) * 86400, always positive.
  // The quotient by 86400 is then the day number shifted by 39 whole eras.
  localparam int U_W = 41;
  localparam logic [U_W-1:0] SEC_BIAS = 41'd554450486400;
  localparam int LO_W     = 7;          // 86400 = 128 * 675
  localparam int DAYQ_DIV = 675;
  localparam int HI_W     = 17;         // top slice of the seconds / 128
  localparam int AL_W     = 17;         // lower slice of the seconds / 128
  localparam int Q1_W     = 7;
  localparam int Q2_W     = 17;

  // Day number and its parts
  localparam int ZP_W  = 24;            // biased day number
  localparam int REM_W = 17;            // second of the day
  localparam int ERA_W = 7;             // biased era
  localparam int DOE_W = 18;            // day of era
  localparam int YOE_W = 9;             // year of era
  localparam int DOY_W = 9;             // day of March-based year
  localparam int MP_W  = 4;
  localparam int K1_W  = 7;

  localparam int DAYS_PER_ERA = 146097;
  localparam int DAYS_4Y      = 1460;
  localparam int DAYS_100Y    = 36524;
  localparam int DAYS_YEAR    = 365;
  localparam int YEARS_ERA    = 400;
  localparam logic [YEAR_W-1:0] YEAR_BIAS = 16'd15600;  // 39 eras of 400 years
  localparam int WD_SHIFT     = 3;      // biased day number + 3, mod 7, gives Sunday = 0
  localparam int SEC_PER_MIN  = 60;
  localparam int MTOT_W       = 11;     // minute of the day

  // Pipeline depth
  localparam int SPLIT_LAT = 5;
  localparam int CIV_LAT   = 11;
  localparam int TOD_LAT   = 4;
  localparam int PIPE_LAT  = SPLIT_LAT + CIV_LAT;

  typedef struct packed {
    logic signed [YEAR_W-1:0] year_num;
    logic [MONTH_W-1:0]       month_num;
    logic [MDAY_W-1:0]        day_of_month;
    logic [WDAY_W-1:0]        weekday;
    logic [YDAY_W-1:0]        ordinal_day;
  } civ_res_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour_of_day;
    logic [MIN_W-1:0]  minute_of_hour;
    logic [SEC_W-1:0]  second_of_minute;
  } tod_res_t;

  // First day of each March-based month, (153 * mp + 2) / 5
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] v;
    unique case (mp)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // Days in the calendar year before the first of month m
  function automatic logic [YDAY_W-1:0] days_before(input logic leap,
                                                    input logic [MONTH_W-1:0] m);
    logic [YDAY_W-1:0] v;
    unique case (m)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      default: v = 9'd0;
    endcase
    if (leap && (m > 4'd2)) begin
      v = v + 9'd1;
    end
    return v;
  endfunction

endpackage

@@ rtl/utcal_in_if.sv @@
interface utcal_in_if import utcal_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SECS_W-1:0] unix_seconds;
  logic signed [OFF_W-1:0]  offset_minutes;

  modport source (output valid, unix_seconds, offset_minutes, input ready);
  modport sink   (input valid, unix_seconds, offset_minutes, output ready);
endinterface

@@ rtl/utcal_out_if.sv @@
interface utcal_out_if import utcal_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [YEAR_W-1:0] year_num;
  logic [MONTH_W-1:0]       month_num;
  logic [MDAY_W-1:0]        day_of_month;
  logic [HOUR_W-1:0]        hour_of_day;
  logic [MIN_W-1:0]         minute_of_hour;
  logic [SEC_W-1:0]         second_of_minute;
  logic [WDAY_W-1:0]        weekday;
  logic [YDAY_W-1:0]        ordinal_day;

  modport source (output valid, year_num, month_num, day_of_month, hour_of_day,
                  minute_of_hour, second_of_minute, weekday, ordinal_day,
                  input ready);
  modport sink   (input valid, year_num, month_num, day_of_month, hour_of_day,
                  minute_of_hour, second_of_minute, weekday, ordinal_day,
                  output ready);
endinterface

@@ rtl/unix_time_to_calendar.sv @@
// Channel  Dir  Handshake        Payload
// in_ch    in   valid / ready    unix_seconds (40 s), offset_minutes (11 s)
// out_ch   out  valid / ready    year_num, month_num, day_of_month, hour_of_day,
//                                minute_of_hour, second_of_minute, weekday,
//                                ordinal_day
//
// One transfer per cycle in each direction while out_ch takes results. The
// pipeline depth comes from the chain of constant dividers (by 675 twice,
// 146097, 1460, 365), each a reciprocal multiply stage and a correction
// stage. Reset (rst_n low, synchronous) clears the stage valid bits only.
// When a result waits and out_ch.ready is low the whole pipeline holds and
// in_ch.ready drops; nothing is lost or repeated.
module unix_time_to_calendar import utcal_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  utcal_in_if.sink    in_ch,
  utcal_out_if.source out_ch
);

  logic [PIPE_LAT-1:0] vld_r;
  logic                en;
  logic [ZP_W-1:0]     zp;
  logic [REM_W-1:0]    rem;
  civ_res_t            civ;
  tod_res_t            tod;

  // Global advance: move unless the output stage holds an untaken result
  assign en          = !vld_r[PIPE_LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_ch.valid};
    end
  end

  utcal_split u_split (
    .clk, .en,
    .secs_i (in_ch.unix_seconds),
    .off_i  (in_ch.offset_minutes),
    .zp_o   (zp),
    .rem_o  (rem)
  );

  utcal_civil u_civil (
    .clk, .en,
    .zp_i  (zp),
    .res_o (civ)
  );

  utcal_tod u_tod (
    .clk, .en,
    .rem_i (rem),
    .res_o (tod)
  );

  assign out_ch.valid            = vld_r[PIPE_LAT-1];
  assign out_ch.year_num         = civ.year_num;
  assign out_ch.month_num        = civ.month_num;
  assign out_ch.day_of_month     = civ.day_of_month;
  assign out_ch.weekday          = civ.weekday;
  assign out_ch.ordinal_day      = civ.ordinal_day;
  assign out_ch.hour_of_day      = tod.hour_of_day;
  assign out_ch.minute_of_hour   = tod.minute_of_hour;
  assign out_ch.second_of_minute = tod.second_of_minute;

  // Input side only backs off while a finished result is blocked
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without a blocked result");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.month_num >= 4'd1) && (out_ch.month_num <= 4'd12) &&
                     (out_ch.day_of_month >= 5'd1) &&
                     (out_ch.ordinal_day >= 9'd1) && (out_ch.ordinal_day <= 9'd366))
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.hour_of_day <= 5'd23) && (out_ch.minute_of_hour <= 6'd59) &&
                     (out_ch.second_of_minute <= 6'd59) && (out_ch.weekday <= 3'd6))
    else $error("time of day or weekday out of range");

  // January: ordinal day and day of month agree across the two date paths
  a_january: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.month_num == 4'd1)) |->
      (out_ch.ordinal_day == YDAY_W'(out_ch.day_of_month)))
    else $error("day of year disagrees with January date");

endmodule

@@ rtl/utcal_cdiv.sv @@
module utcal_cdiv #(
  parameter int XW = 17,
  parameter int QW = 11,
  parameter int D  = 60,
  localparam int RW = $clog2(D)
) (
  input  logic          clk,
  input  logic          en,
  input  logic [XW-1:0] x_i,
  output logic [QW-1:0] q_o,
  output logic [RW-1:0] r_o
);

  // Reciprocal estimate is exact or one low for any dividend below 2^SH
  localparam int SH = 32;
  localparam logic [SH-1:0] RECIP = SH'((64'd1 << SH) / D);

  logic [XW+SH-1:0] prod_r, prod_nxt;
  logic [XW-1:0]    x_r;
  logic [XW-1:0]    q_est, q_mul, r_est;
  logic             fix;
  logic [QW-1:0]    q_r, q_nxt;
  logic [RW-1:0]    r_r, r_nxt;

  // Stage 1: multiply by the reciprocal
  assign prod_nxt = (XW+SH)'(x_i) * (XW+SH)'(RECIP);

  // Stage 2: back-multiply, remainder, one correction step
  always_comb begin
    q_est = prod_r[XW+SH-1:SH];
    q_mul = q_est * XW'(D);
    r_est = x_r - q_mul;
    fix   = (r_est >= XW'(D));
    q_nxt = fix ? QW'(q_est + XW'(1)) : QW'(q_est);
    r_nxt = fix ? RW'(r_est - XW'(D)) : RW'(r_est);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      x_r    <= x_i;
      q_r    <= q_nxt;
      r_r    <= r_nxt;
    end
  end

  assign q_o = q_r;
  assign r_o = r_r;

endmodule

@@ rtl/utcal_split.sv @@
module utcal_split import utcal_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [SECS_W-1:0] secs_i,
  input  logic signed [OFF_W-1:0]  off_i,
  output logic [ZP_W-1:0]          zp_o,
  output logic [REM_W-1:0]         rem_o
);

  logic signed [OFF_W-1:0] off_c;
  logic signed [LOC_W-1:0] off_sec;
  logic [U_W:0]            u_sum;
  logic [U_W-1:0]          u_r;
  logic [AL_W-1:0]         al_p2_r, al_p3_r;
  logic [LO_W-1:0]         lo_p2_r, lo_p3_r, lo_p4_r, lo_p5_r;
  logic [Q1_W-1:0]         q1_p3, q1_p4_r, q1_p5_r;
  logic [9:0]              r1_p3, r2_p5;
  logic [Q2_W-1:0]         q2_p5;

  // P1: clamp offset, add to seconds, bias positive
  always_comb begin
    if (off_i < OFF_LOW) begin
      off_c = OFF_LOW;
    end else if (off_i > OFF_HIGH) begin
      off_c = OFF_HIGH;
    end else begin
      off_c = off_i;
    end
    off_sec = LOC_W'(off_c) * 17'sd60;
    u_sum   = (U_W+1)'(secs_i) + (U_W+1)'(off_sec) + (U_W+1)'(SEC_BIAS);
  end

  // Divide (u / 128) by 675 in two slices: high slice first, then
  // remainder joined with the low slice.
  utcal_cdiv #(.XW(HI_W), .QW(Q1_W), .D(DAYQ_DIV)) u_div_hi (
    .clk, .en,
    .x_i (u_r[U_W-1 -: HI_W]),
    .q_o (q1_p3),
    .r_o (r1_p3)
  );

  utcal_cdiv #(.XW(10 + AL_W), .QW(Q2_W), .D(DAYQ_DIV)) u_div_lo (
    .clk, .en,
    .x_i ({r1_p3, al_p3_r}),
    .q_o (q2_p5),
    .r_o (r2_p5)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      u_r     <= u_sum[U_W-1:0];
      al_p2_r <= u_r[LO_W +: AL_W];
      al_p3_r <= al_p2_r;
      lo_p2_r <= u_r[LO_W-1:0];
      lo_p3_r <= lo_p2_r;
      lo_p4_r <= lo_p3_r;
      lo_p5_r <= lo_p4_r;
      q1_p4_r <= q1_p3;
      q1_p5_r <= q1_p4_r;
    end
  end

  assign zp_o  = {q1_p5_r, q2_p5};
  assign rem_o = {r2_p5, lo_p5_r};

endmodule

@@ rtl/utcal_tod.sv @@
module utcal_tod import utcal_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [REM_W-1:0] rem_i,
  output tod_res_t         res_o
);

  localparam int PAD = CIV_LAT - TOD_LAT;

  logic [MTOT_W-1:0] mtot_t2;
  logic [SEC_W-1:0]  sec_t2, sec_t3_r, sec_t4_r;
  logic [HOUR_W-1:0] hour_t4;
  logic [MIN_W-1:0]  min_t4;
  tod_res_t          pad_r [PAD];

  // Seconds of the day -> minute of the day, second
  utcal_cdiv #(.XW(REM_W), .QW(MTOT_W), .D(SEC_PER_MIN)) u_div_min (
    .clk, .en,
    .x_i (rem_i),
    .q_o (mtot_t2),
    .r_o (sec_t2)
  );

  // Minute of the day -> hour, minute
  utcal_cdiv #(.XW(MTOT_W), .QW(HOUR_W), .D(SEC_PER_MIN)) u_div_hour (
    .clk, .en,
    .x_i (mtot_t2),
    .q_o (hour_t4),
    .r_o (min_t4)
  );

  // Delay to line up with the date path
  always_ff @(posedge clk) begin
    if (en) begin
      sec_t3_r <= sec_t2;
      sec_t4_r <= sec_t3_r;
      pad_r[0] <= '{hour_of_day: hour_t4, minute_of_hour: min_t4,
                    second_of_minute: sec_t4_r};
      for (int i = 1; i < PAD; i++) begin
        pad_r[i] <= pad_r[i-1];
      end
    end
  end

  assign res_o = pad_r[PAD-1];

endmodule

@@ rtl/utcal_civil.sv @@
module utcal_civil import utcal_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [ZP_W-1:0] zp_i,
  output civ_res_t        res_o
);

  localparam int OCT_N = (ZP_W + 3) / 3;
  localparam int WD_N  = CIV_LAT - 1;

  // weekday
  logic [3*OCT_N-1:0] wd_pad;
  logic [5:0]         oct_sum;
  logic [3:0]         fold;
  logic [WDAY_W-1:0]  wd_nxt;
  logic [WDAY_W-1:0]  wd_r [WD_N];

  // date path
  logic [ERA_W-1:0]  era_c2, era_c3_r, era_c4_r, era_c5_r, era_c6_r, era_c7_r;
  logic [ERA_W-1:0]  era_c8_r, era_c9_r;
  logic [DOE_W-1:0]  doe_c2, doe_c3_r, doe_c4_r, doe_c5_r, doe_c6_r, doe_c7_r;
  logic [2:0]        k2_nxt, k2_c3_r, k2_c4_r;
  logic              k3_c3_r, k3_c4_r;
  logic [K1_W-1:0]   k1_c4;
  logic [DOE_W-1:0]  t_c5_r;
  logic [YOE_W-1:0]  yoe_c7, yoe_c8_r, yoe_c9_r;
  logic [1:0]        cent;
  logic [DOE_W-1:0]  doy_full;
  logic [DOY_W-1:0]  doy_c8_r, doy_c9_r;
  logic [MP_W-1:0]   mp_nxt, mp_c9_r;
  logic              jan_feb;
  logic [YOE_W-1:0]  yl;
  logic              leap_nxt, leap_c10_r;
  logic [DOY_W-1:0]  dstart;
  logic [MDAY_W-1:0] d_nxt, d_c10_r;
  logic [MONTH_W-1:0] m_nxt, m_c10_r;
  logic [YEAR_W-1:0] y_nxt, y_c10_r;
  civ_res_t          res_r;

  // C1: weekday by folding octal digits (8 = 1 mod 7)
  always_comb begin
    wd_pad  = (3*OCT_N)'(zp_i) + (3*OCT_N)'(WD_SHIFT);
    oct_sum = '0;
    for (int i = 0; i < OCT_N; i++) begin
      oct_sum = oct_sum + 6'(wd_pad[3*i +: 3]);
    end
    fold = 4'(oct_sum[5:3]) + 4'(oct_sum[2:0]);
    if (fold >= 4'd14) begin
      wd_nxt = 3'(fold - 4'd14);
    end else if (fold >= 4'd7) begin
      wd_nxt = 3'(fold - 4'd7);
    end else begin
      wd_nxt = 3'(fold);
    end
  end

  // C1-C2: era and day of era
  utcal_cdiv #(.XW(ZP_W), .QW(ERA_W), .D(DAYS_PER_ERA)) u_div_era (
    .clk, .en,
    .x_i (zp_i),
    .q_o (era_c2),
    .r_o (doe_c2)
  );

  // C3-C4: doe / 1460 by divider; doe / 36524 and the last-day flag by compare
  utcal_cdiv #(.XW(DOE_W), .QW(K1_W), .D(DAYS_4Y)) u_div_4y (
    .clk, .en,
    .x_i (doe_c2),
    .q_o (k1_c4),
    .r_o ()
  );

  always_comb begin
    if (doe_c2 >= DOE_W'(4 * DAYS_100Y)) begin
      k2_nxt = 3'd4;
    end else if (doe_c2 >= DOE_W'(3 * DAYS_100Y)) begin
      k2_nxt = 3'd3;
    end else if (doe_c2 >= DOE_W'(2 * DAYS_100Y)) begin
      k2_nxt = 3'd2;
    end else if (doe_c2 >= DOE_W'(DAYS_100Y)) begin
      k2_nxt = 3'd1;
    end else begin
      k2_nxt = 3'd0;
    end
  end

  // C6-C7: year of era
  utcal_cdiv #(.XW(DOE_W), .QW(YOE_W), .D(DAYS_YEAR)) u_div_year (
    .clk, .en,
    .x_i (t_c5_r),
    .q_o (yoe_c7),
    .r_o ()
  );

  // C8: day of the March-based year
  always_comb begin
    if (yoe_c7 >= 9'd300) begin
      cent = 2'd3;
    end else if (yoe_c7 >= 9'd200) begin
      cent = 2'd2;
    end else if (yoe_c7 >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
    doy_full = doe_c7_r - DOE_W'(yoe_c7) * DOE_W'(DAYS_YEAR)
               - DOE_W'(yoe_c7[YOE_W-1:2]) + DOE_W'(cent);
  end

  // C9: March-based month by table compare
  always_comb begin
    mp_nxt = '0;
    for (int i = 1; i < 12; i++) begin
      if (doy_c8_r >= month_start(MP_W'(i))) begin
        mp_nxt = mp_nxt + MP_W'(1);
      end
    end
  end

  // C10: day, month, year, leap flag
  always_comb begin
    jan_feb  = (mp_c9_r >= 4'd10);
    m_nxt    = jan_feb ? (mp_c9_r - 4'd9) : (mp_c9_r + 4'd3);
    dstart   = month_start(mp_c9_r);
    d_nxt    = MDAY_W'(doy_c9_r - dstart + 9'd1);
    yl       = yoe_c9_r + YOE_W'(jan_feb);
    // year of era 0 and 400 are era starts, hence leap
    leap_nxt = (yl[1:0] == 2'd0) && !((yl == 9'd100) || (yl == 9'd200) || (yl == 9'd300));
    y_nxt    = YEAR_W'(era_c9_r) * YEAR_W'(YEARS_ERA) + YEAR_W'(yoe_c9_r)
               + YEAR_W'(jan_feb) - YEAR_BIAS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wd_r[0] <= wd_nxt;
      for (int i = 1; i < WD_N; i++) begin
        wd_r[i] <= wd_r[i-1];
      end
      // C3
      era_c3_r   <= era_c2;
      doe_c3_r   <= doe_c2;
      k2_c3_r    <= k2_nxt;
      k3_c3_r    <= (doe_c2 == DOE_W'(DAYS_PER_ERA - 1));
      // C4
      era_c4_r   <= era_c3_r;
      doe_c4_r   <= doe_c3_r;
      k2_c4_r    <= k2_c3_r;
      k3_c4_r    <= k3_c3_r;
      // C5
      t_c5_r     <= doe_c4_r - DOE_W'(k1_c4) + DOE_W'(k2_c4_r) - DOE_W'(k3_c4_r);
      era_c5_r   <= era_c4_r;
      doe_c5_r   <= doe_c4_r;
      // C6, C7
      era_c6_r   <= era_c5_r;
      doe_c6_r   <= doe_c5_r;
      era_c7_r   <= era_c6_r;
      doe_c7_r   <= doe_c6_r;
      // C8
      doy_c8_r   <= doy_full[DOY_W-1:0];
      yoe_c8_r   <= yoe_c7;
      era_c8_r   <= era_c7_r;
      // C9
      mp_c9_r    <= mp_nxt;
      doy_c9_r   <= doy_c8_r;
      yoe_c9_r   <= yoe_c8_r;
      era_c9_r   <= era_c8_r;
      // C10
      d_c10_r    <= d_nxt;
      m_c10_r    <= m_nxt;
      y_c10_r    <= y_nxt;
      leap_c10_r <= leap_nxt;
      // C11: ordinal day and result register
      res_r.year_num     <= y_c10_r;
      res_r.month_num    <= m_c10_r;
      res_r.day_of_month <= d_c10_r;
      res_r.weekday      <= wd_r[WD_N-1];
      res_r.ordinal_day  <= days_before(leap_c10_r, m_c10_r) + YDAY_W'(d_c10_r);
    end
  end

  assign res_o = res_r;

endmodule
